### rtl/gbsp_pkg.sv
package gbsp_pkg;

    // Parse phases. Each value doubles as the section code of a byte that
    // is consumed in that phase.
    typedef enum logic [3:0] {
        PH_SIG     = 4'd0,
        PH_SCREEN  = 4'd1,
        PH_GCT     = 4'd2,
        PH_TAG     = 4'd3,
        PH_LABEL   = 4'd4,
        PH_GCE     = 4'd5,
        PH_SUBLEN  = 4'd6,
        PH_SUBDATA = 4'd7,
        PH_APP     = 4'd8,
        PH_IMG     = 4'd9,
        PH_LCT     = 4'd10,
        PH_LZW     = 4'd11
    } phase_t;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_BAD_LABEL  = 3'd1,
        ERR_GCE_SIZE   = 3'd2,
        ERR_GCE_TERM   = 3'd3,
        ERR_APP_SIZE   = 3'd4,
        ERR_BAD_TAG    = 3'd5
    } err_t;

    localparam logic [3:0] SEC_END     = 4'd12;
    localparam logic [3:0] SEC_IGNORED = 4'd13;

    localparam logic [3:0] FC_NONE       = 4'd0;
    localparam logic [3:0] FC_SCR_WIDTH  = 4'd1;
    localparam logic [3:0] FC_SCR_HEIGHT = 4'd2;
    localparam logic [3:0] FC_GCT_SIZE   = 4'd3;
    localparam logic [3:0] FC_DELAY      = 4'd4;
    localparam logic [3:0] FC_TRANSP     = 4'd5;
    localparam logic [3:0] FC_LEFT       = 4'd6;
    localparam logic [3:0] FC_LCT_SIZE   = 4'd10;
    localparam logic [3:0] FC_LZW_SIZE   = 4'd11;

    localparam logic [7:0] TAG_TRAILER = 8'h3B;
    localparam logic [7:0] TAG_EXT     = 8'h21;
    localparam logic [7:0] TAG_IMAGE   = 8'h2C;
    localparam logic [7:0] LBL_GCE     = 8'hF9;
    localparam logic [7:0] LBL_COMMENT = 8'hFE;
    localparam logic [7:0] LBL_APP     = 8'hFF;
    localparam logic [7:0] LBL_PLAIN   = 8'h01;
    localparam logic [7:0] GCE_SIZE    = 8'd4;
    localparam logic [7:0] APP_SIZE    = 8'd11;

    localparam logic [9:0] SIG_LEN = 10'd6;

    typedef struct packed {
        phase_t      phase;
        logic [9:0]  remaining;
        logic [3:0]  pos;
        logic [7:0]  low_half;
        status_t     status;
        err_t        held_err;
    } parse_state_t;

    typedef struct packed {
        logic [3:0]  section;
        logic [3:0]  fcode;
        logic [15:0] fval;
        err_t        err;
        logic        done;
    } parse_result_t;

    // Color table size in bytes from a packed flags byte: 3 * 2^(n+1),
    // or zero when the table flag is clear. The largest value is 768.
    function automatic logic [9:0] table_size(input logic [7:0] flags);
        logic [9:0] t;
        t = 10'd6 << flags[2:0];
        return flags[7] ? t : 10'd0;
    endfunction

endpackage

### rtl/gbsp_step.sv
module gbsp_step
    import gbsp_pkg::*;
(
    input  parse_state_t  cur,
    input  logic [7:0]    data_byte,
    output parse_state_t  nxt,
    output parse_result_t res
);

    logic [3:0]  fcode;
    logic [15:0] fval;
    err_t        err;
    logic [3:0]  section;
    logic [9:0]  tsize;

    assign tsize = table_size(data_byte);

    always_comb
    begin
        nxt     = cur;
        fcode   = FC_NONE;
        fval    = 16'd0;
        err     = ERR_NONE;
        section = 4'(cur.phase);

        if (cur.status == ST_RUN)
        begin
            unique case (cur.phase)
                PH_SIG:
                begin
                    if (cur.remaining <= 10'd1)
                    begin
                        nxt.phase     = PH_SCREEN;
                        nxt.remaining = 10'd0;
                        nxt.pos       = 4'd0;
                    end
                    else
                    begin
                        nxt.remaining = cur.remaining - 10'd1;
                    end
                end
                PH_SCREEN:
                begin
                    priority if (cur.pos == 4'd0 || cur.pos == 4'd2)
                        nxt.low_half = data_byte;
                    else if (cur.pos == 4'd1)
                    begin
                        fcode = FC_SCR_WIDTH;
                        fval  = {data_byte, cur.low_half};
                    end
                    else if (cur.pos == 4'd3)
                    begin
                        fcode = FC_SCR_HEIGHT;
                        fval  = {data_byte, cur.low_half};
                    end
                    else if (cur.pos == 4'd4)
                    begin
                        fcode         = FC_GCT_SIZE;
                        fval          = 16'(tsize);
                        nxt.low_half  = tsize[7:0];
                        nxt.remaining = tsize;
                    end
                    else
                    begin
                        nxt.low_half = cur.low_half;
                    end
                    if (cur.pos >= 4'd6)
                    begin
                        nxt.phase = (cur.remaining != 10'd0) ? PH_GCT : PH_TAG;
                        nxt.pos   = 4'd0;
                        if (cur.remaining == 10'd0)
                            nxt.remaining = 10'd0;
                    end
                    else
                    begin
                        nxt.pos = cur.pos + 4'd1;
                    end
                end
                PH_GCT, PH_LCT:
                begin
                    if (cur.remaining <= 10'd1)
                    begin
                        nxt.phase     = (cur.phase == PH_GCT) ? PH_TAG : PH_LZW;
                        nxt.remaining = 10'd0;
                        nxt.pos       = 4'd0;
                    end
                    else
                    begin
                        nxt.remaining = cur.remaining - 10'd1;
                    end
                end
                PH_TAG:
                begin
                    priority if (data_byte == TAG_TRAILER || data_byte == 8'd0)
                    begin
                        section    = SEC_END;
                        nxt.status = ST_DONE;
                    end
                    else if (data_byte == TAG_EXT)
                    begin
                        nxt.phase     = PH_LABEL;
                        nxt.remaining = 10'd0;
                        nxt.pos       = 4'd0;
                    end
                    else if (data_byte == TAG_IMAGE)
                    begin
                        nxt.phase     = PH_IMG;
                        nxt.remaining = 10'd0;
                        nxt.pos       = 4'd0;
                    end
                    else
                    begin
                        err = ERR_BAD_TAG;
                    end
                end
                PH_LABEL:
                begin
                    nxt.remaining = 10'd0;
                    nxt.pos       = 4'd0;
                    priority if (data_byte == LBL_GCE)
                        nxt.phase = PH_GCE;
                    else if (data_byte == LBL_COMMENT || data_byte == LBL_PLAIN)
                        nxt.phase = PH_SUBLEN;
                    else if (data_byte == LBL_APP)
                        nxt.phase = PH_APP;
                    else
                    begin
                        err           = ERR_BAD_LABEL;
                        nxt.remaining = cur.remaining;
                        nxt.pos       = cur.pos;
                    end
                end
                PH_GCE:
                begin
                    priority if (cur.pos == 4'd0)
                    begin
                        if (data_byte != GCE_SIZE)
                            err = ERR_GCE_SIZE;
                    end
                    else if (cur.pos == 4'd2)
                        nxt.low_half = data_byte;
                    else if (cur.pos == 4'd3)
                    begin
                        fcode = FC_DELAY;
                        fval  = {data_byte, cur.low_half};
                    end
                    else if (cur.pos == 4'd4)
                    begin
                        fcode = FC_TRANSP;
                        fval  = {8'd0, data_byte};
                    end
                    else if (cur.pos >= 4'd5)
                    begin
                        if (data_byte != 8'd0)
                            err = ERR_GCE_TERM;
                    end
                    else
                    begin
                        nxt.low_half = cur.low_half;
                    end
                    if (err == ERR_NONE)
                    begin
                        if (cur.pos >= 4'd5)
                        begin
                            nxt.phase     = PH_TAG;
                            nxt.remaining = 10'd0;
                            nxt.pos       = 4'd0;
                        end
                        else
                        begin
                            nxt.pos = cur.pos + 4'd1;
                        end
                    end
                end
                PH_APP:
                begin
                    priority if (cur.pos == 4'd0)
                    begin
                        if (data_byte != APP_SIZE)
                            err = ERR_APP_SIZE;
                        else
                        begin
                            nxt.pos       = 4'd1;
                            nxt.remaining = 10'(APP_SIZE);
                        end
                    end
                    else if (cur.remaining <= 10'd1)
                    begin
                        nxt.phase     = PH_SUBLEN;
                        nxt.remaining = 10'd0;
                        nxt.pos       = 4'd0;
                    end
                    else
                    begin
                        nxt.remaining = cur.remaining - 10'd1;
                    end
                end
                PH_SUBLEN:
                begin
                    nxt.phase     = (data_byte == 8'd0) ? PH_TAG : PH_SUBDATA;
                    nxt.remaining = {2'b00, data_byte};
                    nxt.pos       = 4'd0;
                end
                PH_SUBDATA:
                begin
                    if (cur.remaining <= 10'd1)
                    begin
                        nxt.phase     = PH_SUBLEN;
                        nxt.remaining = 10'd0;
                        nxt.pos       = 4'd0;
                    end
                    else
                    begin
                        nxt.remaining = cur.remaining - 10'd1;
                    end
                end
                PH_IMG:
                begin
                    if (cur.pos >= 4'd8)
                    begin
                        // Packed flags byte closes the image descriptor.
                        fcode         = FC_LCT_SIZE;
                        fval          = 16'(tsize);
                        nxt.phase     = (tsize != 10'd0) ? PH_LCT : PH_LZW;
                        nxt.remaining = tsize;
                        nxt.pos       = 4'd0;
                    end
                    else
                    begin
                        if (cur.pos[0] == 1'b0)
                            nxt.low_half = data_byte;
                        else
                        begin
                            fcode = FC_LEFT + {2'b00, cur.pos[2:1]};
                            fval  = {data_byte, cur.low_half};
                        end
                        nxt.pos = cur.pos + 4'd1;
                    end
                end
                PH_LZW:
                begin
                    fcode         = FC_LZW_SIZE;
                    fval          = {8'd0, data_byte};
                    nxt.phase     = PH_SUBLEN;
                    nxt.remaining = 10'd0;
                    nxt.pos       = 4'd0;
                end
                default:
                begin
                    nxt.phase     = PH_TAG;
                    nxt.remaining = 10'd0;
                    nxt.pos       = 4'd0;
                end
            endcase

            if (err != ERR_NONE)
            begin
                nxt.status   = ST_ERR;
                nxt.held_err = err;
                fcode        = FC_NONE;
                fval         = 16'd0;
            end
        end
        else
        begin
            section = SEC_IGNORED;
            err     = cur.held_err;
        end
    end

    always_comb
    begin
        res.section = section;
        res.fcode   = fcode;
        res.fval    = fval;
        res.err     = err;
        res.done    = (nxt.status == ST_DONE);
    end

endmodule

### rtl/gif_block_structure_parser_top.sv
// GIF container parser: labels each byte of a GIF stream with its section and reports
// completed header fields, format errors and end of stream. One byte is accepted per
// clock cycle when the output side keeps up; each result passes through the input
// register, one pass of the parse logic and the result register. The parse state is
// updated as a byte moves into the result register, so the next byte sees it at once.
// in_ready follows out_ready combinationally when both registers are full. After an error,
// the trailer or a zero tag the parser stays put until reset.
module gif_block_structure_parser_top
    import gbsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  byte_section,
    output logic [3:0]  field_code,
    output logic [15:0] field_value,
    output logic [2:0]  error_code,
    output logic        stream_done
);

    logic          in_valid_reg;
    logic [7:0]    byte_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t res_next;
    parse_result_t res_reg;
    logic          out_valid_reg;
    logic          advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    gbsp_step u_step (
        .cur       (state_reg),
        .data_byte (byte_reg),
        .nxt       (state_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_SIG, remaining: SIG_LEN, pos: 4'd0,
                               low_half: 8'd0, status: ST_RUN, held_err: ERR_NONE};
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            byte_reg <= data_byte;
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid    = out_valid_reg;
    assign byte_section = res_reg.section;
    assign field_code   = res_reg.fcode;
    assign field_value  = res_reg.fval;
    assign error_code   = res_reg.err;
    assign stream_done  = res_reg.done;

`ifndef ASSERT_OFF
    // Once the parser has stopped, its status never changes again.
    a_sticky_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.status != ST_RUN) |=> (state_reg.status == $past(state_reg.status)))
        else $error("parser status left its final value");

    // A result that carries an error never carries a field.
    a_err_no_field: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error_code != ERR_NONE) |-> (field_code == FC_NONE && field_value == 16'd0))
        else $error("error result carries a field");

    // The end of stream can only be flagged on the trailer or zero tag byte or later bytes,
    // and never together with an error.
    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stream_done) |-> (error_code == ERR_NONE
            && (byte_section == SEC_END || byte_section == SEC_IGNORED)))
        else $error("stream_done on a wrong section or with an error");

    // A result with no field reports a zero value.
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && field_code == FC_NONE) |-> (field_value == 16'd0))
        else $error("nonzero value without a field");
`endif

endmodule

### tb/gif_block_structure_parser_top_test.sv
module gif_block_structure_parser_top_test;
    import gbsp_pkg::*;

    localparam int unsigned ITEM_GOAL  = 1800;
    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned MAX_GAP    = 18;
    localparam int unsigned DRAIN      = 8;

    localparam logic [7:0] BLOCK_TERM = 8'h00;
    localparam logic [7:0] TAG_ZERO   = 8'h00;

    typedef enum int unsigned {
        BLK_GCE,
        BLK_COMMENT,
        BLK_PLAIN,
        BLK_APP,
        BLK_IMAGE
    } block_kind_t;

    typedef enum int unsigned {
        END_TRAILER,
        END_ZERO_TAG,
        END_BAD_TAG,
        END_BAD_LABEL,
        END_GCE_SIZE,
        END_GCE_TERM,
        END_APP_SIZE
    } ending_t;

    typedef struct {
        logic [7:0]    value;
        bit            typed;
        parse_result_t want;
    } header_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  byte_section;
    logic [3:0]  field_code;
    logic [15:0] field_value;
    logic [2:0]  error_code;
    logic        stream_done;

    gif_block_structure_parser_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .byte_section (byte_section),
        .field_code   (field_code),
        .field_value  (field_value),
        .error_code   (error_code),
        .stream_done  (stream_done)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Parser state as the predictor sees it.
    phase_t      cur_phase;
    logic [9:0]  left_count;
    logic [3:0]  field_idx;
    logic [7:0]  low_byte;
    status_t     run_state;
    err_t        sticky_err;

    parse_result_t pending_results[$];
    header_row_t   opening_rows[$];
    logic [7:0]    gif_stream[$];

    int unsigned fail_count = 0;
    int unsigned sent = 0;
    int unsigned idle_cycles = 0;
    bit          calm_in = 1'b0;
    bit          calm_out = 1'b0;

    function automatic logic [15:0] color_table_bytes(input logic [7:0] flags);
        if (!flags[7])
        begin
            return 16'd0;
        end
        return 16'd3 * (16'd2 << flags[2:0]);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic move_to(input phase_t ph, input logic [9:0] n);
        cur_phase  = ph;
        left_count = n;
        field_idx  = 4'd0;
    endtask

    task automatic parse_byte(input logic [7:0] b, output parse_result_t r);
        logic [3:0]  p;
        logic [3:0]  fc;
        logic [15:0] fv;
        err_t        er;
        p  = field_idx;
        fc = FC_NONE;
        fv = 16'd0;
        er = ERR_NONE;
        r.section = cur_phase;
        if (run_state != ST_RUN)
        begin
            r.section = SEC_IGNORED;
            r.err     = sticky_err;
        end
        else
        begin
            case (cur_phase)
                PH_SIG:
                begin
                    if (left_count <= 1) move_to(PH_SCREEN, 10'd0);
                    else left_count--;
                end
                PH_SCREEN:
                begin
                    if (p == 0 || p == 2)
                    begin
                        low_byte = b;
                    end
                    else if (p == 1)
                    begin
                        fc = FC_SCR_WIDTH;
                        fv = {b, low_byte};
                    end
                    else if (p == 3)
                    begin
                        fc = FC_SCR_HEIGHT;
                        fv = {b, low_byte};
                    end
                    else if (p == 4)
                    begin
                        fc = FC_GCT_SIZE;
                        fv = color_table_bytes(b);
                        low_byte   = fv[7:0];
                        left_count = fv[9:0];
                    end
                    if (p >= 6)
                    begin
                        if (left_count != 0) move_to(PH_GCT, left_count);
                        else move_to(PH_TAG, 10'd0);
                    end
                    else
                    begin
                        field_idx = p + 4'd1;
                    end
                end
                PH_GCT, PH_LCT:
                begin
                    if (left_count <= 1) move_to(cur_phase == PH_GCT ? PH_TAG : PH_LZW, 10'd0);
                    else left_count--;
                end
                PH_TAG:
                begin
                    if (b == TAG_TRAILER || b == TAG_ZERO)
                    begin
                        r.section = SEC_END;
                        run_state = ST_DONE;
                    end
                    else if (b == TAG_EXT) move_to(PH_LABEL, 10'd0);
                    else if (b == TAG_IMAGE) move_to(PH_IMG, 10'd0);
                    else er = ERR_BAD_TAG;
                end
                PH_LABEL:
                begin
                    if (b == LBL_GCE) move_to(PH_GCE, 10'd0);
                    else if (b == LBL_COMMENT || b == LBL_PLAIN) move_to(PH_SUBLEN, 10'd0);
                    else if (b == LBL_APP) move_to(PH_APP, 10'd0);
                    else er = ERR_BAD_LABEL;
                end
                PH_GCE:
                begin
                    if (p == 0)
                    begin
                        if (b != GCE_SIZE) er = ERR_GCE_SIZE;
                    end
                    else if (p == 2)
                    begin
                        low_byte = b;
                    end
                    else if (p == 3)
                    begin
                        fc = FC_DELAY;
                        fv = {b, low_byte};
                    end
                    else if (p == 4)
                    begin
                        fc = FC_TRANSP;
                        fv = {8'd0, b};
                    end
                    else if (p >= 5)
                    begin
                        if (b != BLOCK_TERM) er = ERR_GCE_TERM;
                    end
                    if (er == ERR_NONE)
                    begin
                        if (p >= 5) move_to(PH_TAG, 10'd0);
                        else field_idx = p + 4'd1;
                    end
                end
                PH_APP:
                begin
                    if (p == 0)
                    begin
                        if (b != APP_SIZE)
                        begin
                            er = ERR_APP_SIZE;
                        end
                        else
                        begin
                            field_idx  = 4'd1;
                            left_count = {2'b00, APP_SIZE};
                        end
                    end
                    else if (left_count <= 1)
                    begin
                        move_to(PH_SUBLEN, 10'd0);
                    end
                    else
                    begin
                        left_count--;
                    end
                end
                PH_SUBLEN:
                begin
                    if (b == BLOCK_TERM) move_to(PH_TAG, 10'd0);
                    else move_to(PH_SUBDATA, {2'b00, b});
                end
                PH_SUBDATA:
                begin
                    if (left_count <= 1) move_to(PH_SUBLEN, 10'd0);
                    else left_count--;
                end
                PH_IMG:
                begin
                    if (p < 8)
                    begin
                        if (!p[0])
                        begin
                            low_byte = b;
                        end
                        else
                        begin
                            // Odd positions close left, top, width and height in turn.
                            fc = FC_LEFT + (p >> 1);
                            fv = {b, low_byte};
                        end
                        field_idx = p + 4'd1;
                    end
                    else
                    begin
                        fc = FC_LCT_SIZE;
                        fv = color_table_bytes(b);
                        if (fv != 0) move_to(PH_LCT, fv[9:0]);
                        else move_to(PH_LZW, 10'd0);
                    end
                end
                PH_LZW:
                begin
                    fc = FC_LZW_SIZE;
                    fv = {8'd0, b};
                    move_to(PH_SUBLEN, 10'd0);
                end
                default:
                begin
                    move_to(PH_TAG, 10'd0);
                end
            endcase
            if (er != ERR_NONE)
            begin
                run_state  = ST_ERR;
                sticky_err = er;
                fc = FC_NONE;
                fv = 16'd0;
            end
            r.err = er;
        end
        r.fcode = fc;
        r.fval  = fv;
        r.done  = (run_state == ST_DONE);
    endtask

    task automatic add_typed(input logic [7:0] b, input logic [3:0] sec,
                             input logic [3:0] fc, input logic [15:0] fv);
        header_row_t row;
        row.value        = b;
        row.typed        = 1'b1;
        row.want.section = sec;
        row.want.fcode   = fc;
        row.want.fval    = fv;
        row.want.err     = ERR_NONE;
        row.want.done    = 1'b0;
        opening_rows.push_back(row);
    endtask

    task automatic add_predicted(input logic [7:0] b);
        header_row_t row;
        row.value = b;
        row.typed = 1'b0;
        row.want  = '0;
        opening_rows.push_back(row);
    endtask

    task automatic put_random(input int unsigned n);
        repeat (n) gif_stream.push_back(rand_byte());
    endtask

    // Zero to three sub-blocks, mostly short, then the block terminator.
    task automatic put_subblocks();
        int unsigned count;
        int unsigned len;
        count = $urandom_range(0, 3);
        repeat (count)
        begin
            if ($urandom_range(0, 15) == 0) len = $urandom_range(1, 255);
            else len = $urandom_range(1, 12);
            gif_stream.push_back(8'(len));
            put_random(len);
        end
        gif_stream.push_back(BLOCK_TERM);
    endtask

    task automatic build_stream();
        block_kind_t kind;
        ending_t     ending;
        logic [7:0]  v;
        while (gif_stream.size() < ITEM_GOAL)
        begin
            kind = block_kind_t'($urandom_range(BLK_GCE, BLK_IMAGE));
            case (kind)
                BLK_GCE:
                begin
                    gif_stream.push_back(TAG_EXT);
                    gif_stream.push_back(LBL_GCE);
                    gif_stream.push_back(GCE_SIZE);
                    put_random(4);
                    gif_stream.push_back(BLOCK_TERM);
                end
                BLK_COMMENT, BLK_PLAIN:
                begin
                    gif_stream.push_back(TAG_EXT);
                    gif_stream.push_back(kind == BLK_COMMENT ? LBL_COMMENT : LBL_PLAIN);
                    put_subblocks();
                end
                BLK_APP:
                begin
                    gif_stream.push_back(TAG_EXT);
                    gif_stream.push_back(LBL_APP);
                    gif_stream.push_back(APP_SIZE);
                    put_random(32'(APP_SIZE));
                    put_subblocks();
                end
                default:
                begin
                    gif_stream.push_back(TAG_IMAGE);
                    put_random(8);
                    // Keep local tables small most of the time.
                    v = rand_byte();
                    if ($urandom_range(0, 9) != 0) v[2:0] = 3'($urandom_range(0, 2));
                    gif_stream.push_back(v);
                    put_random(32'(color_table_bytes(v)));
                    put_random(1);
                    put_subblocks();
                end
            endcase
        end

        ending = ending_t'($urandom_range(END_TRAILER, END_APP_SIZE));
        case (ending)
            END_TRAILER: gif_stream.push_back(TAG_TRAILER);
            END_ZERO_TAG: gif_stream.push_back(TAG_ZERO);
            END_BAD_TAG:
            begin
                do v = rand_byte();
                while (v == TAG_ZERO || v == TAG_TRAILER || v == TAG_EXT || v == TAG_IMAGE);
                gif_stream.push_back(v);
            end
            END_BAD_LABEL:
            begin
                gif_stream.push_back(TAG_EXT);
                do v = rand_byte();
                while (v == LBL_GCE || v == LBL_COMMENT || v == LBL_PLAIN || v == LBL_APP);
                gif_stream.push_back(v);
            end
            END_GCE_SIZE:
            begin
                gif_stream.push_back(TAG_EXT);
                gif_stream.push_back(LBL_GCE);
                do v = rand_byte();
                while (v == GCE_SIZE);
                gif_stream.push_back(v);
            end
            END_GCE_TERM:
            begin
                gif_stream.push_back(TAG_EXT);
                gif_stream.push_back(LBL_GCE);
                gif_stream.push_back(GCE_SIZE);
                put_random(4);
                gif_stream.push_back(8'($urandom_range(1, 255)));
            end
            default:
            begin
                gif_stream.push_back(TAG_EXT);
                gif_stream.push_back(LBL_APP);
                do v = rand_byte();
                while (v == APP_SIZE);
                gif_stream.push_back(v);
            end
        endcase
        // Bytes after the end or the error are only labeled as ignored.
        put_random(16);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input parse_result_t typed_want);
        int unsigned   gap;
        parse_result_t r;
        if (sent % 64 == 0) calm_in = ($urandom_range(0, 3) == 0);
        gap = calm_in ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do @(posedge clk);
        while (!in_ready);
        parse_byte(b, r);
        pending_results.push_back(typed ? typed_want : r);
        sent++;
    endtask

    initial
    begin : stimulus
        int unsigned k;
        in_valid  <= 1'b0;
        data_byte <= 8'd0;
        rst_n     <= 1'b0;

        cur_phase  = PH_SIG;
        left_count = SIG_LEN;
        field_idx  = 4'd0;
        low_byte   = 8'd0;
        run_state  = ST_RUN;
        sticky_err = ERR_NONE;

        // Signature, screen descriptor with extreme sizes, a six byte global
        // table, then a graphic control block with extreme delay and index.
        add_typed(8'h47, PH_SIG, FC_NONE, 16'd0);
        add_typed(8'h49, PH_SIG, FC_NONE, 16'd0);
        add_typed(8'h46, PH_SIG, FC_NONE, 16'd0);
        add_typed(8'h38, PH_SIG, FC_NONE, 16'd0);
        add_typed(8'h39, PH_SIG, FC_NONE, 16'd0);
        add_typed(8'h61, PH_SIG, FC_NONE, 16'd0);
        add_typed(8'hFF, PH_SCREEN, FC_NONE, 16'd0);
        add_typed(8'hFF, PH_SCREEN, FC_SCR_WIDTH, 16'hFFFF);
        add_typed(8'h00, PH_SCREEN, FC_NONE, 16'd0);
        add_typed(8'h00, PH_SCREEN, FC_SCR_HEIGHT, 16'd0);
        add_typed(8'hF8, PH_SCREEN, FC_GCT_SIZE, 16'd6);
        add_typed(8'h00, PH_SCREEN, FC_NONE, 16'd0);
        add_typed(8'hFF, PH_SCREEN, FC_NONE, 16'd0);
        for (k = 0; k < 6; k++) add_predicted(rand_byte());
        add_typed(TAG_EXT, PH_TAG, FC_NONE, 16'd0);
        add_typed(LBL_GCE, PH_LABEL, FC_NONE, 16'd0);
        add_typed(GCE_SIZE, PH_GCE, FC_NONE, 16'd0);
        add_predicted(8'h1D);
        add_typed(8'hFF, PH_GCE, FC_NONE, 16'd0);
        add_typed(8'hFF, PH_GCE, FC_DELAY, 16'hFFFF);
        add_typed(8'hFF, PH_GCE, FC_TRANSP, 16'h00FF);
        add_typed(BLOCK_TERM, PH_GCE, FC_NONE, 16'd0);
        build_stream();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (opening_rows[i])
        begin
            send_byte(opening_rows[i].value, opening_rows[i].typed, opening_rows[i].want);
        end
        foreach (gif_stream[i])
        begin
            send_byte(gif_stream[i], 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial
    begin : result_sink
        int unsigned stall;
        int unsigned taken;
        taken = 0;
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (taken % 50 == 0) calm_out = ($urandom_range(0, 3) == 0);
            stall = calm_out ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk);
            while (!(out_valid && out_ready));
            taken++;
        end
    end

    always @(posedge clk)
    begin
        parse_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("unexpected transfer: section %0d field %0d value %h error %0d done %0b",
                             byte_section, field_code, field_value, error_code, stream_done);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                if (byte_section !== want.section || field_code !== want.fcode ||
                    field_value !== want.fval || error_code !== want.err ||
                    stream_done !== want.done)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("mismatch (expected/actual): section %0d/%0d field %0d/%0d",
                                 want.section, byte_section, want.fcode, field_code);
                        $display("    value %h/%h error %0d/%0d done %0b/%0b",
                                 want.fval, field_value, want.err, error_code,
                                 want.done, stream_done);
                    end
                end
            end
        end
    end

    // Ends the run if no transfer happens on either side for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

### gif_block_structure_parser_top.f
rtl/gbsp_pkg.sv
rtl/gbsp_step.sv
rtl/gif_block_structure_parser_top.sv
tb/gif_block_structure_parser_top_test.sv
